// ===== design/fbpa_pkg.sv =====
// Package for the fixed block pool allocator.
// Holds field widths, status and action codes, controller states and the
// command and status structs. No dependencies.
package fbpa_pkg;

  localparam int POOL_DEPTH      = 256;
  localparam int RESET_POOL_SIZE = 256;

  localparam int LINK_W   = 9;
  localparam int INDEX_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_POOL_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NONE_USED  = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC
  } fbpa_state_t;

  typedef struct packed {
    logic sweep_start;
    logic sweep_step;
    logic accept;
    logic commit;
  } fbpa_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic out_ready;
  } fbpa_sts_t;

endpackage

// ===== design/fbpa_ctrl.sv =====
// Controller state machine for the fixed block pool allocator.
// Sequences the link memory initialization pass and the item flow through the idle and execute states.
// Depends on fbpa_pkg.
module fbpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              in_valid,
  output logic              in_stall,
  input  fbpa_pkg::fbpa_sts_t sts,
  output fbpa_pkg::fbpa_cmd_t cmd
);

  fbpa_pkg::fbpa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbpa_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (cfg_we) begin
      state_nxt = fbpa_pkg::ST_INIT;
    end else begin
      unique case (state_r)
        fbpa_pkg::ST_INIT: begin
          if (sts.sweep_last) state_nxt = fbpa_pkg::ST_IDLE;
        end
        fbpa_pkg::ST_IDLE: begin
          if (in_valid) state_nxt = fbpa_pkg::ST_EXEC;
        end
        fbpa_pkg::ST_EXEC: begin
          if (sts.out_ready) state_nxt = fbpa_pkg::ST_IDLE;
        end
        default: state_nxt = fbpa_pkg::ST_INIT;
      endcase
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.sweep_start = cfg_we;
    in_stall        = 1'b1;
    unique case (state_r)
      fbpa_pkg::ST_INIT: begin
        cmd.sweep_step = !cfg_we;
      end
      fbpa_pkg::ST_IDLE: begin
        in_stall   = cfg_we;
        cmd.accept = in_valid && !cfg_we;
      end
      fbpa_pkg::ST_EXEC: begin
        cmd.commit = sts.out_ready && !cfg_we;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== design/fbpa_dpath.sv =====
// Datapath for the fixed block pool allocator: link memory, list head,
// block counts, captured item and the result register.
// Depends on fbpa_pkg; driven by commands from fbpa_ctrl.
module fbpa_dpath #(
  parameter int POOL_DEPTH = fbpa_pkg::POOL_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [fbpa_pkg::COUNT_W-1:0]        cfg_wdata,
  input  logic                                in_action,
  input  logic [fbpa_pkg::INDEX_W-1:0]        in_block_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fbpa_pkg::STATUS_W-1:0]       out_status,
  output logic [fbpa_pkg::INDEX_W-1:0]        out_granted_index,
  output logic [fbpa_pkg::COUNT_W-1:0]        out_free_blocks,
  output logic [fbpa_pkg::COUNT_W-1:0]        out_used_blocks,
  input  fbpa_pkg::fbpa_cmd_t                 cmd,
  output fbpa_pkg::fbpa_sts_t                 sts
);

  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int RESET_SIZE_I = (fbpa_pkg::RESET_POOL_SIZE > POOL_DEPTH) ?
                                POOL_DEPTH : fbpa_pkg::RESET_POOL_SIZE;
  localparam logic [fbpa_pkg::COUNT_W-1:0] RESET_SIZE =
    fbpa_pkg::COUNT_W'(RESET_SIZE_I);
  localparam logic [AW-1:0] LAST_ADDR = AW'(POOL_DEPTH - 1);

  logic [fbpa_pkg::LINK_W-1:0] link_mem [POOL_DEPTH];

  logic [fbpa_pkg::LINK_W-1:0]   head_r, head_nxt;
  logic [fbpa_pkg::COUNT_W-1:0]  free_r, free_nxt;
  logic [fbpa_pkg::COUNT_W-1:0]  used_r, used_nxt;
  logic [AW-1:0]                 sweep_cnt_r;
  logic                          act_r;
  logic [fbpa_pkg::INDEX_W-1:0]  blk_r;
  logic [fbpa_pkg::LINK_W-1:0]   link_rd_r;
  logic                          out_valid_r;
  logic [fbpa_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [fbpa_pkg::INDEX_W-1:0]  granted_r, granted_nxt;
  logic [fbpa_pkg::COUNT_W-1:0]  free_out_r;
  logic [fbpa_pkg::COUNT_W-1:0]  used_out_r;
  logic [fbpa_pkg::COUNT_W-1:0]  cfg_size;
  logic                          link_we;
  logic                          blk_in_mem;

  // A written size of zero becomes one; anything past the memory depth is cut.
  always_comb begin
    priority if (cfg_wdata == '0) begin
      cfg_size = fbpa_pkg::COUNT_W'(1);
    end else if (32'(cfg_wdata) > POOL_DEPTH) begin
      cfg_size = fbpa_pkg::COUNT_W'(POOL_DEPTH);
    end else begin
      cfg_size = cfg_wdata;
    end
  end

  assign blk_in_mem = 32'(blk_r) < POOL_DEPTH;

  always_comb begin
    head_nxt    = head_r;
    free_nxt    = free_r;
    used_nxt    = used_r;
    status_nxt  = fbpa_pkg::STATUS_OK;
    granted_nxt = '0;
    link_we     = 1'b0;
    if (act_r == fbpa_pkg::ACT_ALLOC) begin
      // A head beyond the link memory can only follow bad frees; it reads as empty.
      if (free_r == '0 || 32'(head_r) >= POOL_DEPTH) begin
        status_nxt = fbpa_pkg::STATUS_POOL_EMPTY;
      end else begin
        granted_nxt = fbpa_pkg::INDEX_W'(head_r);
        head_nxt    = link_rd_r;
        free_nxt    = free_r - 1'b1;
        used_nxt    = used_r + 1'b1;
      end
    end else begin
      if (used_r == '0) begin
        status_nxt = fbpa_pkg::STATUS_NONE_USED;
      end else begin
        link_we  = blk_in_mem;
        head_nxt = fbpa_pkg::LINK_W'(blk_r);
        used_nxt = used_r - 1'b1;
        free_nxt = free_r + 1'b1;
      end
    end
  end

  // Link memory: one write port shared by the initialization pass and frees,
  // one registered read port for the head's successor.
  always_ff @(posedge clk) begin
    if (cmd.sweep_step) begin
      link_mem[sweep_cnt_r] <= fbpa_pkg::LINK_W'(32'(sweep_cnt_r) + 1);
    end else if (cmd.commit && link_we) begin
      link_mem[AW'(blk_r)] <= head_r;
    end
    if (cmd.accept) begin
      link_rd_r <= link_mem[AW'(head_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      free_r      <= RESET_SIZE;
      used_r      <= '0;
      sweep_cnt_r <= '0;
    end else if (cmd.sweep_start) begin
      head_r      <= '0;
      free_r      <= cfg_size;
      used_r      <= '0;
      sweep_cnt_r <= '0;
    end else begin
      if (cmd.sweep_step) begin
        sweep_cnt_r <= sweep_cnt_r + 1'b1;
      end
      if (cmd.commit) begin
        head_r <= head_nxt;
        free_r <= free_nxt;
        used_r <= used_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r <= in_action;
      blk_r <= in_block_index;
    end
    if (cmd.commit) begin
      status_r   <= status_nxt;
      granted_r  <= granted_nxt;
      free_out_r <= free_nxt;
      used_out_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.sweep_last = sweep_cnt_r == LAST_ADDR;
  assign sts.out_ready  = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_granted_index = granted_r;
  assign out_free_blocks   = free_out_r;
  assign out_used_blocks   = used_out_r;

endmodule

// ===== design/fixed_block_pool_allocator_top.sv =====
// For each item: in the cycle it is accepted the link of the
// current head block is read from the synchronous link memory, and in the
// execute state the list and counts are updated and the result is loaded into
// the output register; a stalled output holds the item in the execute state
// until the register frees up, while the next item can already be accepted
// once the result is registered. After reset and after every pool_size write
// the link memory is initialized one entry per cycle, all POOL_DEPTH entries,
// with in_stall held high throughout.
//
// Top level of the fixed block pool allocator. Instantiates fbpa_ctrl and
// fbpa_dpath; depends on fbpa_pkg.
module fixed_block_pool_allocator_top #(
  parameter int POOL_DEPTH = fbpa_pkg::POOL_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fbpa_pkg::COUNT_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [fbpa_pkg::INDEX_W-1:0]  in_block_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fbpa_pkg::STATUS_W-1:0] out_status,
  output logic [fbpa_pkg::INDEX_W-1:0]  out_granted_index,
  output logic [fbpa_pkg::COUNT_W-1:0]  out_free_blocks,
  output logic [fbpa_pkg::COUNT_W-1:0]  out_used_blocks
);

  fbpa_pkg::fbpa_cmd_t cmd;
  fbpa_pkg::fbpa_sts_t sts;

  fbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fbpa_dpath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wdata         (cfg_wdata),
    .in_action         (in_action),
    .in_block_index    (in_block_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_free_blocks   (out_free_blocks),
    .out_used_blocks   (out_used_blocks),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule
